/* rtl/rtbg_pkg.sv */
package rtbg_pkg;

   // CSR register indexes
   localparam int CSR_ADDR_WIDTH = 3;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   localparam csr_addr_type CSR_PHASE_STEP      = 3'd0;
   localparam csr_addr_type CSR_AMPLITUDE       = 3'd1;
   localparam csr_addr_type CSR_ONSET_DELAY     = 3'd2;
   localparam csr_addr_type CSR_TONE_LENGTH     = 3'd3;
   localparam csr_addr_type CSR_RAMP_LENGTH     = 3'd4;
   localparam csr_addr_type CSR_RAMP_RECIPROCAL = 3'd5;

   localparam int CSR_DATA_WIDTH = 32;

   // field widths
   localparam int PHASE_WIDTH  = 32;
   localparam int AMP_WIDTH    = 24;
   localparam int DELAY_WIDTH  = 20;
   localparam int TLEN_WIDTH   = 21;
   localparam int RAMP_WIDTH   = 20;
   localparam int RECIP_WIDTH  = 25;
   localparam int SAMPLE_WIDTH = 25;
   localparam int SINE_WIDTH   = 16;

   // pi/2 in Q30, unity in Q24
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q24     = 64'd16777216;

   // shared multiplier operand and product widths
   localparam int MUL_WIDTH  = 25;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;

endpackage

/* rtl/ramped_tone_burst_generator.sv */
// Ramped tone burst generator. Every request on the req_ channel yields exactly one
// response on the rsp_ channel: first onset_delay zero samples, then tone_length samples
// of amplitude * sin(phase) with a linear rise over the first ramp_length samples and a
// linear fall over the last ramp_length, then zeros with tuser (done) set until a request
// with restart = 1 starts a new burst. req_tdata[0] = 1 clears the burst state and that
// same request returns the first sample of the new burst. A zero sample (delay or done)
// passes through check and put, the done sample that ends a tone cut short by a smaller
// tone_length through check, tone and put, a tone sample through check, tone, mag, then
// factor, saturate, scale and round once per active ramp (0, 1 or 2), then sign and put;
// every multiply (amplitude, ramp factor, ramp scaling) uses one shared registered 25x25 multiplier.
// The sine comes from a quarter-wave ROM of SINE_TABLE_DEPTH entries with registered read.
// req_tready is high only while the sequencer is idle; the finished response sits in an
// output register, so the next request is taken while it waits. Write the CSRs (index =
// register number: phase_step, amplitude, onset_delay, tone_length, ramp_length,
// ramp_reciprocal) only while no request is in flight; csr_ready is always high.
module ramped_tone_burst_generator #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int INDEX_WIDTH      = 21
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata[0] = restart, tdata[7:1] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   // response: tdata[24:0] = sample (signed Q8.16), tdata[31:25] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   // tuser[0] = done_res
   output logic                                rsp_tuser,
   // CSR write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  rtbg_pkg::csr_addr_type              csr_addr,
   input  logic [rtbg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   // compare width: wide enough for the sample index and the tone length
   localparam int CW = (INDEX_WIDTH > rtbg_pkg::TLEN_WIDTH) ? INDEX_WIDTH
                                                             : rtbg_pkg::TLEN_WIDTH;
   localparam int MW = rtbg_pkg::MUL_WIDTH;
   localparam int PW = rtbg_pkg::PROD_WIDTH;

   typedef logic [rtbg_pkg::SINE_WIDTH-1:0] rom_type [SINE_TABLE_DEPTH];

   // quarter-wave sine, Taylor series in Q30, rounded to 16 bits and saturated
   function automatic rom_type build_rom();
      rom_type            t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        e;
      logic signed [63:0] sum;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         x    = (64'(i) * rtbg_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         e = ($unsigned(sum) + 64'd8192) >> 14;
         if (e > 64'd65535) begin
            e = 64'd65535;
         end
         t[i] = e[rtbg_pkg::SINE_WIDTH-1:0];
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_TONE,
      S_MAG,
      S_FACT,
      S_SAT,
      S_SCALE,
      S_ROUND,
      S_SIGN,
      S_PUT
   } state_type;

   // configuration registers
   logic [rtbg_pkg::PHASE_WIDTH-1:0] phase_step_ff;
   logic [rtbg_pkg::AMP_WIDTH-1:0]   amplitude_ff;
   logic [rtbg_pkg::DELAY_WIDTH-1:0] onset_delay_ff;
   logic [rtbg_pkg::TLEN_WIDTH-1:0]  tone_length_ff;
   logic [rtbg_pkg::RAMP_WIDTH-1:0]  ramp_length_ff;
   logic [rtbg_pkg::RECIP_WIDTH-1:0] ramp_recip_ff;

   // values derived from configuration, refreshed every cycle
   logic [CW-1:0] tlen_m1_ff;
   logic [CW-1:0] tlen_m1_in;
   logic [CW-1:0] thr_ff;
   logic [CW-1:0] thr_in;
   logic [CW-1:0] tlen_eff;

   // burst state
   state_type                        state_ff;
   logic [INDEX_WIDTH-1:0]           idx_ff;
   logic [rtbg_pkg::PHASE_WIDTH-1:0] phase_ff;
   logic                             fin_ff;
   logic                             in_tone_ff;

   // datapath
   logic [IDX_W-1:0]                 rom_addr;
   logic [IDX_W-1:0]                 rom_off;
   logic [rtbg_pkg::SINE_WIDTH-1:0]  rom_q_ff;
   logic                             one_ff;
   logic [MW-1:0]                    mul_a;
   logic [MW-1:0]                    mul_b;
   logic [PW-1:0]                    prod_ff;
   logic [rtbg_pkg::AMP_WIDTH-1:0]   mag_ff;
   logic [rtbg_pkg::RECIP_WIDTH-1:0] f_ff;
   logic [rtbg_pkg::RAMP_WIDTH-1:0]  rise_cnt_ff;
   logic [rtbg_pkg::RAMP_WIDTH-1:0]  fall_cnt_ff;
   logic                             rise_ff;
   logic                             fall_ff;
   logic                             last_ff;
   logic                             pass_ff;
   logic [CW-1:0]                    k_ext;
   logic [CW-1:0]                    delay_ext;
   logic [CW-1:0]                    ramp_ext;
   logic                             ramp_on;

   // pending response and output register
   logic [rtbg_pkg::SAMPLE_WIDTH-1:0] res_sample_ff;
   logic                              res_last_ff;
   logic                              res_done_ff;
   logic                              rsp_tvalid_ff;
   logic [rtbg_pkg::SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                              rsp_last_ff;
   logic                              rsp_done_ff;

   logic req_take;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(32 - rtbg_pkg::SAMPLE_WIDTH){1'b0}}, rsp_sample_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   // ---------------------------------------------------------------- CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         amplitude_ff   <= '0;
         onset_delay_ff <= '0;
         tone_length_ff <= rtbg_pkg::TLEN_WIDTH'(1);
         ramp_length_ff <= '0;
         ramp_recip_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_addr)
            rtbg_pkg::CSR_PHASE_STEP:
               phase_step_ff <= csr_wdata[rtbg_pkg::PHASE_WIDTH-1:0];
            rtbg_pkg::CSR_AMPLITUDE:
               amplitude_ff <= csr_wdata[rtbg_pkg::AMP_WIDTH-1:0];
            rtbg_pkg::CSR_ONSET_DELAY:
               onset_delay_ff <= csr_wdata[rtbg_pkg::DELAY_WIDTH-1:0];
            rtbg_pkg::CSR_TONE_LENGTH:
               tone_length_ff <= csr_wdata[rtbg_pkg::TLEN_WIDTH-1:0];
            rtbg_pkg::CSR_RAMP_LENGTH:
               ramp_length_ff <= csr_wdata[rtbg_pkg::RAMP_WIDTH-1:0];
            rtbg_pkg::CSR_RAMP_RECIPROCAL:
               ramp_recip_ff <= csr_wdata[rtbg_pkg::RECIP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // zero tone length counts as one sample; falling ramp starts at tlen - ramp_length
   always_comb begin
      tlen_eff   = (tone_length_ff == '0) ? CW'(1) : CW'(tone_length_ff);
      ramp_ext   = CW'(ramp_length_ff);
      tlen_m1_in = tlen_eff - CW'(1);
      thr_in     = (tlen_eff > ramp_ext) ? (tlen_eff - ramp_ext) : '0;
   end

   always_ff @(posedge clock) begin
      tlen_m1_ff <= tlen_m1_in;
      thr_ff     <= thr_in;
   end

   // ---------------------------------------------------------------- sine ROM
   // odd quadrants read the mirrored index; mirror of zero is sine = 1
   assign rom_off  = phase_ff[rtbg_pkg::PHASE_WIDTH-3 -: IDX_W];
   assign rom_addr = phase_ff[rtbg_pkg::PHASE_WIDTH-2] ? (IDX_W'(0) - rom_off) : rom_off;

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
      one_ff   <= phase_ff[rtbg_pkg::PHASE_WIDTH-2] && (rom_off == '0);
   end

   // ---------------------------------------------------------------- shared multiplier
   always_comb begin
      case (state_ff)
         S_TONE: begin
            mul_a = MW'(amplitude_ff);
            mul_b = one_ff ? MW'(17'h10000) : MW'(rom_q_ff);
         end
         S_FACT: begin
            mul_a = pass_ff ? MW'(fall_cnt_ff) : MW'(rise_cnt_ff);
            mul_b = MW'(ramp_recip_ff);
         end
         S_SCALE: begin
            mul_a = MW'(mag_ff);
            mul_b = MW'(f_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   assign k_ext     = CW'(idx_ff);
   assign delay_ext = CW'(onset_delay_ff);
   assign ramp_on   = (ramp_length_ff != '0);

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         phase_ff      <= '0;
         fin_ff        <= 1'b0;
         in_tone_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         pass_ff       <= 1'b0;
      end else begin
         // drop the response once taken, unless a new one is loaded below
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_PUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (req_tdata[0]) begin
                     idx_ff     <= '0;
                     phase_ff   <= '0;
                     fin_ff     <= 1'b0;
                     in_tone_ff <= 1'b0;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (fin_ff) begin
                  res_sample_ff <= '0;
                  res_last_ff   <= 1'b0;
                  res_done_ff   <= 1'b1;
                  state_ff      <= S_PUT;
               end else if (in_tone_ff) begin
                  state_ff <= S_TONE;
               end else if (k_ext >= delay_ext) begin
                  in_tone_ff <= 1'b1;
                  idx_ff     <= '0;
                  state_ff   <= S_TONE;
               end else begin
                  idx_ff        <= idx_ff + INDEX_WIDTH'(1);
                  res_sample_ff <= '0;
                  res_last_ff   <= 1'b0;
                  res_done_ff   <= 1'b0;
                  state_ff      <= S_PUT;
               end
            end
            S_TONE: begin
               // the multiplier takes amplitude * sine in this cycle
               if (k_ext > tlen_m1_ff) begin
                  fin_ff        <= 1'b1;
                  res_sample_ff <= '0;
                  res_last_ff   <= 1'b0;
                  res_done_ff   <= 1'b1;
                  state_ff      <= S_PUT;
               end else begin
                  rise_ff     <= ramp_on && (k_ext < ramp_ext);
                  fall_ff     <= ramp_on && (k_ext >= thr_ff);
                  last_ff     <= (k_ext == tlen_m1_ff);
                  rise_cnt_ff <= k_ext[rtbg_pkg::RAMP_WIDTH-1:0];
                  fall_cnt_ff <= rtbg_pkg::RAMP_WIDTH'(tlen_m1_ff - k_ext);
                  state_ff    <= S_MAG;
               end
            end
            S_MAG: begin
               mag_ff  <= rtbg_pkg::AMP_WIDTH'((prod_ff + PW'(32768)) >> 16);
               pass_ff <= !rise_ff;
               if (rise_ff || fall_ff) begin
                  state_ff <= S_FACT;
               end else begin
                  state_ff <= S_SIGN;
               end
            end
            S_FACT: begin
               state_ff <= S_SAT;
            end
            S_SAT: begin
               // saturate the ramp factor to one
               f_ff <= (prod_ff > PW'(rtbg_pkg::ONE_Q24)) ?
                       rtbg_pkg::RECIP_WIDTH'(rtbg_pkg::ONE_Q24) :
                       prod_ff[rtbg_pkg::RECIP_WIDTH-1:0];
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               mag_ff <= rtbg_pkg::AMP_WIDTH'((prod_ff + PW'(24'h800000)) >> 24);
               if (!pass_ff && fall_ff) begin
                  pass_ff  <= 1'b1;
                  state_ff <= S_FACT;
               end else begin
                  state_ff <= S_SIGN;
               end
            end
            S_SIGN: begin
               res_sample_ff <= phase_ff[rtbg_pkg::PHASE_WIDTH-1] ?
                                (rtbg_pkg::SAMPLE_WIDTH'(0) - rtbg_pkg::SAMPLE_WIDTH'(mag_ff)) :
                                rtbg_pkg::SAMPLE_WIDTH'(mag_ff);
               res_last_ff   <= last_ff;
               res_done_ff   <= 1'b0;
               if (last_ff) begin
                  fin_ff <= 1'b1;
               end else begin
                  idx_ff <= idx_ff + INDEX_WIDTH'(1);
               end
               phase_ff <= phase_ff + phase_step_ff;
               state_ff <= S_PUT;
            end
            S_PUT: begin
               // hold until the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_sample_ff <= res_sample_ff;
                  rsp_last_ff   <= res_last_ff;
                  rsp_done_ff   <= res_done_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/rtbg_checker.sv */
module rtbg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [7:0]                          req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [31:0]                         rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                rsp_tuser,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input rtbg_pkg::csr_addr_type              csr_addr,
   input logic [rtbg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a done response carries a zero sample and no last flag
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0 && !rsp_tlast)
      else $error("done response with data or last");

   // one request at a time: busy right after accepting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind ramped_tone_burst_generator rtbg_checker u_rtbg_checker (.*);

/* test/ramped_tone_burst_generator_tb.sv */
module ramped_tone_burst_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SINE_DEPTH   = 1024;
   localparam longint      QUARTER_Q30  = 64'd1686629713;  // pi/2 in Q30
   localparam longint      UNITY_Q24    = 64'd16777216;
   localparam int          RANDOM_ITEMS = 400;
   localparam int          QUIET_AFTER  = 340;             // phases begun past this many requests get no idling

   // one response of the block: sample, last flag, done flag
   typedef struct packed {
      logic [24:0] sample;
      logic        last;
      logic        done;
   } tone_result_type;

   // one row of the directed table: either a CSR write or a request
   typedef struct packed {
      logic                   is_csr;
      rtbg_pkg::csr_addr_type addr;
      logic [31:0]            data;
      logic                   restart;
      logic                   known;     // want holds a hand-worked result
      tone_result_type        want;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [7:0]                          req_tdata;    // [0] restart, [7:1] zero
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [31:0]                         rsp_tdata;    // [24:0] sample, [31:25] zero
   logic                                rsp_tlast;
   logic                                rsp_tuser;    // [0] done
   logic                                csr_valid;
   logic                                csr_ready;
   rtbg_pkg::csr_addr_type              csr_addr;
   logic [rtbg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   // predictor copy of the CSRs
   logic [31:0] cfg_phase_step;
   logic [23:0] cfg_amplitude;
   logic [19:0] cfg_onset;
   logic [20:0] cfg_tone_len;
   logic [19:0] cfg_ramp_len;
   logic [24:0] cfg_ramp_recip;

   // predictor copy of the burst state
   logic [20:0] tone_pos;
   logic [31:0] tone_phase;
   logic        burst_over;
   logic        tone_active;
   logic [15:0] sine_rom [SINE_DEPTH];

   tone_result_type expected_samples [$];
   int              mismatch_count = 0;
   int              gap_odds  = 0;   // 0 disables sender gaps, else 1 in gap_odds
   int              stall_odds = 0;  // same for receiver stalls
   int              stall_left = 0;

   ramped_tone_burst_generator #(
      .SINE_TABLE_DEPTH(SINE_DEPTH),
      .INDEX_WIDTH     (21)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // scale a magnitude by count/ramp_length, factor saturated at one
   function automatic longint unsigned ramp_attenuate(longint unsigned mag,
                                                      longint unsigned count);
      longint unsigned factor;
      factor = count * cfg_ramp_recip;
      if (factor > UNITY_Q24) factor = UNITY_Q24;
      return (mag * factor + (64'd1 << 23)) >> 24;
   endfunction

   // advance the burst by one request and return the sample it produces
   function automatic tone_result_type predict_sample(logic restart);
      tone_result_type r;
      logic [1:0]      quad;
      longint unsigned idx, s, mag, thr, k, tl;
      r = '0;
      if (restart) begin
         tone_pos    = '0;
         tone_phase  = '0;
         burst_over  = 1'b0;
         tone_active = 1'b0;
      end
      if (burst_over) begin
         r.done = 1'b1;
         return r;
      end
      // count out the onset delay first; a delay lowered below the count ends it at once
      if (!tone_active) begin
         if (tone_pos >= cfg_onset) begin
            tone_active = 1'b1;
            tone_pos    = '0;
         end else begin
            tone_pos = tone_pos + 21'd1;
            return r;
         end
      end
      tl = (cfg_tone_len == 0) ? 64'd1 : 64'(cfg_tone_len);
      k  = 64'(tone_pos);
      // tone length shrunk below the current index: burst is over
      if (k >= tl) begin
         burst_over = 1'b1;
         r.done     = 1'b1;
         return r;
      end
      quad = tone_phase[31:30];
      idx  = ({34'd0, tone_phase[29:0]} * SINE_DEPTH) >> 30;
      // odd quadrants run the table backwards; the mirror of entry zero is full scale
      if (quad[0]) s = (idx == 0) ? 64'd65536 : 64'(sine_rom[SINE_DEPTH - idx]);
      else         s = 64'(sine_rom[idx]);
      mag = (64'(cfg_amplitude) * s + 64'd32768) >> 16;
      if (cfg_ramp_len != 0) begin
         thr = (tl > cfg_ramp_len) ? tl - cfg_ramp_len : 64'd0;
         if (k < cfg_ramp_len) mag = ramp_attenuate(mag, k);
         if (k >= thr)         mag = ramp_attenuate(mag, tl - 1 - k);
      end
      r.sample = mag[24:0];
      if (quad[1]) r.sample = -r.sample;
      if (k == tl - 1) begin
         burst_over = 1'b1;
         r.last     = 1'b1;
      end else begin
         tone_pos = tone_pos + 21'd1;
      end
      tone_phase = tone_phase + cfg_phase_step;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------------------------

   function automatic stim_row_type csr_row(rtbg_pkg::csr_addr_type a, logic [31:0] d);
      stim_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.addr   = a;
      row.data   = d;
      return row;
   endfunction

   function automatic stim_row_type req_row(logic restart);
      stim_row_type row;
      row         = '0;
      row.restart = restart;
      return row;
   endfunction

   function automatic stim_row_type known_row(logic restart, logic [24:0] s, logic l,
                                              logic d);
      stim_row_type row;
      row             = '0;
      row.restart     = restart;
      row.known       = 1'b1;
      row.want.sample = s;
      row.want.last   = l;
      row.want.done   = d;
      return row;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------

   // Offer one request, hold it until taken, and queue what it should produce.
   // Enter and leave on a falling edge; tvalid stays high on exit.
   task automatic send_request(input logic restart, input logic typed,
                               input tone_result_type want);
      tone_result_type predicted;
      if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      predicted = predict_sample(restart);
      expected_samples.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Drop the request and wait out every outstanding response, plus a short settle.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Write one CSR; csr_valid is left high, the caller drops it after the group.
   task automatic write_setting(input rtbg_pkg::csr_addr_type a, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      case (a)
         rtbg_pkg::CSR_PHASE_STEP:      cfg_phase_step = d;
         rtbg_pkg::CSR_AMPLITUDE:       cfg_amplitude  = d[23:0];
         rtbg_pkg::CSR_ONSET_DELAY:     cfg_onset      = d[19:0];
         rtbg_pkg::CSR_TONE_LENGTH:     cfg_tone_len   = d[20:0];
         rtbg_pkg::CSR_RAMP_LENGTH:     cfg_ramp_len   = d[19:0];
         rtbg_pkg::CSR_RAMP_RECIPROCAL: cfg_ramp_recip = d[24:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // The receiver applies random bursts of backpressure.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left  = stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
         rsp_tready <= 1'b0;
         stall_left  = $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Checker: compare each response against the oldest expectation
   // ---------------------------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      tone_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            flag_mismatch("unexpected response", 32'd0, rsp_tdata);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata != {7'd0, want.sample})
               flag_mismatch("sample", {7'd0, want.sample}, rsp_tdata);
            if (rsp_tlast !== want.last)
               flag_mismatch("last", 32'(want.last), 32'(rsp_tlast));
            if (rsp_tuser !== want.done)
               flag_mismatch("done", 32'(want.done), 32'(rsp_tuser));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   initial begin
      stim_row_type    directed_rows [$];
      longint unsigned x, x2, term, e;
      longint          sum;
      int unsigned     tl, rl, dl, rc, count;
      logic [31:0]     step;
      logic [23:0]     amp;
      logic            prev_csr, first_phase;
      int              requests_sent;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_addr   = rtbg_pkg::CSR_PHASE_STEP;
      csr_wdata  = '0;
      reset      = 1'b1;

      // quarter-wave table: 9-term Taylor series in Q30, rounded to Q16
      for (int i = 0; i < SINE_DEPTH; i++) begin
         x    = (64'(i) * QUARTER_Q30) / SINE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum -= longint'(term);
            else            sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         e = (64'(sum) + 64'd8192) >> 14;
         if (e > 64'd65535) e = 64'd65535;
         sine_rom[i] = e[15:0];
      end

      // predictor reset state
      cfg_phase_step = '0;
      cfg_amplitude  = '0;
      cfg_onset      = '0;
      cfg_tone_len   = 21'd1;
      cfg_ramp_len   = '0;
      cfg_ramp_recip = '0;
      tone_pos       = '0;
      tone_phase     = '0;
      burst_over     = 1'b0;
      tone_active    = 1'b0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_rows = '{
         // after reset: a one-sample tone at phase zero, then done, restart repeats it
         known_row(1'b0, 25'd0, 1'b1, 1'b0),
         known_row(1'b0, 25'd0, 1'b0, 1'b1),
         known_row(1'b1, 25'd0, 1'b1, 1'b0),
         // full amplitude, quarter-turn steps: 0, +peak, 0, -peak after two zeros
         csr_row(rtbg_pkg::CSR_AMPLITUDE,   32'h00FF_FFFF),
         csr_row(rtbg_pkg::CSR_PHASE_STEP,  32'h4000_0000),
         csr_row(rtbg_pkg::CSR_TONE_LENGTH, 32'd4),
         csr_row(rtbg_pkg::CSR_ONSET_DELAY, 32'd2),
         known_row(1'b1, 25'd0,        1'b0, 1'b0),
         known_row(1'b0, 25'd0,        1'b0, 1'b0),
         known_row(1'b0, 25'd0,        1'b0, 1'b0),
         known_row(1'b0, 25'h0FF_FFFF, 1'b0, 1'b0),
         known_row(1'b0, 25'd0,        1'b0, 1'b0),
         known_row(1'b0, 25'h100_0001, 1'b1, 1'b0),
         known_row(1'b0, 25'd0,        1'b0, 1'b1),
         // overlapping ramps with an oversized slope (factor saturates at one)
         csr_row(rtbg_pkg::CSR_RAMP_LENGTH,     32'd3),
         csr_row(rtbg_pkg::CSR_RAMP_RECIPROCAL, 32'd16777216),
         csr_row(rtbg_pkg::CSR_ONSET_DELAY,     32'd0),
         csr_row(rtbg_pkg::CSR_PHASE_STEP,      32'h1234_5678),
         req_row(1'b1), req_row(1'b0), req_row(1'b0), req_row(1'b0),
         // ramp half as long as the tone, a long tone, a step one short of a full turn
         csr_row(rtbg_pkg::CSR_RAMP_LENGTH,     32'd524288),
         csr_row(rtbg_pkg::CSR_RAMP_RECIPROCAL, 32'd32),
         csr_row(rtbg_pkg::CSR_TONE_LENGTH,     32'd1048576),
         csr_row(rtbg_pkg::CSR_PHASE_STEP,      32'hFFFF_FFFF),
         req_row(1'b1), req_row(1'b0), req_row(1'b0),
         // shrink the tone below the current index: burst ends
         csr_row(rtbg_pkg::CSR_TONE_LENGTH, 32'd2),
         known_row(1'b0, 25'd0, 1'b0, 1'b1),
         // zero tone length behaves as one sample; longest delay, then cut it short
         csr_row(rtbg_pkg::CSR_TONE_LENGTH, 32'd0),
         csr_row(rtbg_pkg::CSR_RAMP_LENGTH, 32'd0),
         csr_row(rtbg_pkg::CSR_ONSET_DELAY, 32'hF_FFFF),
         known_row(1'b1, 25'd0, 1'b0, 1'b0),
         known_row(1'b0, 25'd0, 1'b0, 1'b0),
         csr_row(rtbg_pkg::CSR_ONSET_DELAY, 32'd1),
         known_row(1'b0, 25'd0, 1'b1, 1'b0)
      };

      gap_odds   = 3;
      stall_odds = 3;
      prev_csr   = 1'b0;
      foreach (directed_rows[j]) begin
         if (directed_rows[j].is_csr) begin
            if (!prev_csr) quiesce();
            write_setting(directed_rows[j].addr, directed_rows[j].data);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr) csr_valid <= 1'b0;
            prev_csr = 1'b0;
            send_request(directed_rows[j].restart, directed_rows[j].known,
                         directed_rows[j].want);
         end
      end

      // Random phases: new settings while idle, then a run of requests. Settings change
      // without a restart in about one phase in four, so delays and tones get cut mid-burst.
      requests_sent = 0;
      first_phase   = 1'b1;
      while (requests_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               // long bursts: only their opening samples get exercised
               tl = $urandom_range(0, 1) ? 1048576 : $urandom_range(1000, 1048576);
               rl = $urandom_range(0, 1) ? 524288 : $urandom_range(0, tl / 2);
               dl = $urandom_range(0, 3) == 0 ? 1048575 : $urandom_range(0, 3);
               count = $urandom_range(3, 12);
            end
            1: begin
               tl = 0;
               rl = $urandom_range(0, 2);
               dl = $urandom_range(0, 4);
               count = $urandom_range(3, 10);
            end
            default: begin
               tl = $urandom_range(1, 40);
               case ($urandom_range(0, 7))
                  0, 1:    rl = 0;
                  2:       rl = $urandom_range(tl / 2 + 1, tl + 4);
                  default: rl = $urandom_range(1, (tl / 2 > 1) ? tl / 2 : 1);
               endcase
               dl = $urandom_range(0, 6);
               count = $urandom_range(3, (dl + tl + 6 > 60) ? 60 : dl + tl + 6);
            end
         endcase
         if (rl == 0 || $urandom_range(0, 7) == 0) rc = $urandom_range(0, 16777216);
         else                                      rc = (16777216 + rl / 2) / rl;
         case ($urandom_range(0, 7))
            0:       amp = 24'd0;
            1:       amp = 24'hFF_FFFF;
            default: amp = 24'($urandom());
         endcase
         case ($urandom_range(0, 7))
            0:       step = {2'($urandom_range(0, 3)), 30'd0};
            1:       step = $urandom_range(0, 4096);
            default: step = $urandom();
         endcase

         quiesce();
         if (first_phase || $urandom_range(0, 2) != 0)
            write_setting(rtbg_pkg::CSR_PHASE_STEP, step);
         if (first_phase || $urandom_range(0, 2) != 0)
            write_setting(rtbg_pkg::CSR_AMPLITUDE, amp);
         if (first_phase || $urandom_range(0, 2) != 0)
            write_setting(rtbg_pkg::CSR_ONSET_DELAY, dl);
         if (first_phase || $urandom_range(0, 2) != 0)
            write_setting(rtbg_pkg::CSR_TONE_LENGTH, tl);
         if (first_phase || $urandom_range(0, 2) != 0)
            write_setting(rtbg_pkg::CSR_RAMP_LENGTH, rl);
         if (first_phase || $urandom_range(0, 2) != 0)
            write_setting(rtbg_pkg::CSR_RAMP_RECIPROCAL, rc);
         csr_valid  <= 1'b0;
         first_phase = 1'b0;

         // pick the idling mix for this phase; the tail of the run has none
         if (requests_sent >= QUIET_AFTER) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: gap_odds = 0;
               1: gap_odds = 2;
               2: gap_odds = 4;
               default: gap_odds = 8;
            endcase
            case ($urandom_range(0, 3))
               0: stall_odds = 0;
               1: stall_odds = 2;
               2: stall_odds = 4;
               default: stall_odds = 8;
            endcase
         end

         for (int r = 0; r < count; r++) begin
            send_request(r == 0 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0),
                         1'b0, '0);
            requests_sent++;
            // now and then hold off until the pipe is empty
            if ($urandom_range(0, 39) == 0) quiesce();
         end
      end

      quiesce();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("ramped_tone_burst_generator verification clean");
      end else begin
         $display("ramped_tone_burst_generator verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("ramped_tone_burst_generator verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/rtbg_pkg.sv
rtl/ramped_tone_burst_generator.sv
rtl/rtbg_checker.sv
test/ramped_tone_burst_generator_tb.sv
